// ===== design/ils_pkg.sv =====
// Shared types and constants for the indexed list store.
package ils_pkg;

    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int CNT_OUT_W = 7;

    // Deepest row the store supports; sizes the cell index on the command bus
    localparam int CAP_MAX = 1024;
    localparam int SLOT_W  = $clog2(CAP_MAX + 1);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } ils_op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } ils_status_t;

    // Broadcast from the control logic to every cell in the row
    typedef struct packed {
        logic               wr;
        logic [SLOT_W-1:0]  pos;
        logic [DATA_W-1:0]  value;
    } ils_ctrl_t;

    localparam logic [DATA_W-1:0] READ_MISS = {DATA_W{1'b1}};

endpackage

// ===== design/ils_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
interface ils_req_if;
    logic                          valid;
    logic                          ready;
    logic [ils_pkg::OP_W-1:0]      opcode;
    logic [ils_pkg::POS_W-1:0]     position;
    logic signed [ils_pkg::DATA_W-1:0] value;

    modport source (output valid, opcode, position, value, input ready);
    modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface ils_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [ils_pkg::DATA_W-1:0] read_value;
    logic [ils_pkg::ST_W-1:0]          status;
    logic [ils_pkg::CNT_OUT_W-1:0]     count;

    modport source (output valid, read_value, status, count, input ready);
    modport sink   (input valid, read_value, status, count, output ready);
endinterface

// ===== design/ils_cell.sv =====
// One storage cell of the list row: holds one entry and shifts on insert.
module ils_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                      clk,
    input  ils_pkg::ils_ctrl_t        ctrl,
    input  logic [ils_pkg::DATA_W-1:0] prev_entry,
    output logic [ils_pkg::DATA_W-1:0] entry,
    output logic [ils_pkg::DATA_W-1:0] hit_value
);
    import ils_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              at_pos;
    logic              above_pos;

    assign at_pos    = (int'(ctrl.pos) == CELL_IDX);
    assign above_pos = (int'(ctrl.pos) <  CELL_IDX);

    // Take the new value at the target slot, take the neighbour's entry above it
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.wr)
        begin
            if (at_pos)
                entry_next = ctrl.value;
            else if (above_pos)
                entry_next = prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry     = entry_reg;
    // Drive own entry onto the read bus only when addressed
    assign hit_value = at_pos ? entry_reg : '0;

endmodule

// ===== design/indexed_list_store.sv =====
// Indexed list store: request channel req carries opcode, position and value;
// response channel rsp returns read_value, status and count, one beat per
// request. Append adds a value at the end, insert places it at a position
// up to the current count and moves later entries up by one, read returns
// the entry at a position below the count (-1 and a bad-index status when
// out of range). A full store refuses append and an in-range insert with a full status.
// The entries live in a row of CAPACITY cells; an insert shifts every cell
// above the position into its neighbour in the same clock edge.
// The response beat is registered and valid in the cycle after the request
// beat is accepted. The store takes one request per cycle while rsp is not
// stalled, as the cell shift and the registered response stage allow.
// When rsp is stalled, the response register holds and req.ready drops
// until the waiting beat is taken.
// Reset clears the count and the response valid; no clearing pass is run,
// the block accepts requests from the first cycle after reset.
module indexed_list_store #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    ils_req_if.sink       req,
    ils_rsp_if.source     rsp
);
    import ils_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic [DATA_W-1:0] rsp_value_reg;
    logic [DATA_W-1:0] rsp_value_next;
    ils_status_t       rsp_status_reg;
    ils_status_t       rsp_status_next;
    logic [CNT_OUT_W-1:0] rsp_count_reg;

    logic              accept;
    logic              full;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    ils_ctrl_t         ctrl;
    ils_op_t           op;
    logic [DATA_W-1:0] read_bus;

    logic [DATA_W-1:0] entries  [CAPACITY];
    logic [DATA_W-1:0] hits     [CAPACITY];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign op        = ils_op_t'(req.opcode);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext   = CMP_W'(req.position);
    assign cnt_ext   = CMP_W'(count_reg);

    // Decode the request beat into a cell command and a response
    always_comb
    begin
        ctrl.wr         = 1'b0;
        ctrl.pos        = SLOT_W'(req.position);
        ctrl.value      = req.value;
        count_next      = count_reg;
        rsp_value_next  = '0;
        rsp_status_next = ST_OK;
        case (op)
            OP_APPEND:
            begin
                ctrl.pos = SLOT_W'(count_reg);
                if (full)
                    rsp_status_next = ST_FULL;
                else
                begin
                    ctrl.wr    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (pos_ext > cnt_ext)
                    rsp_status_next = ST_BAD_INDEX;
                else if (full)
                    rsp_status_next = ST_FULL;
                else
                begin
                    ctrl.wr    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    rsp_status_next = ST_BAD_INDEX;
                    rsp_value_next  = READ_MISS;
                end
                else
                    rsp_value_next = read_bus;
            end
            default:
            begin
                rsp_status_next = ST_OK;
            end
        endcase
    end

    // Row of cells, each fed by its lower neighbour
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev;
        if (i == 0)
        begin : g_first
            assign prev = '0;
        end
        else
        begin : g_rest
            assign prev = entries[i-1];
        end
        ils_cell #(.CELL_IDX(i)) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .prev_entry (prev),
            .entry      (entries[i]),
            .hit_value  (hits[i])
        );
    end

    // Combine the one-hot read bus
    always_comb
    begin
        read_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
            read_bus = read_bus | hits[i];
    end

    // Advance count and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Hold the response payload until the next beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_value_reg  <= rsp_value_next;
            rsp_status_reg <= rsp_status_next;
            rsp_count_reg  <= CNT_OUT_W'(count_next);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_value_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.count      = rsp_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("stored count beyond capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_APPEND && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not grow the count");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rsp_status_next == ST_FULL) |-> full)
        else $error("full status on a store with room");

    a_read_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_READ && rsp_status_next == ST_BAD_INDEX)
        |=> (rsp_value_reg == READ_MISS))
        else $error("bad read did not return all ones");

    a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rsp_status_next != ST_OK) |=> (count_reg == $past(count_reg)))
        else $error("count changed on a refused request");
`endif

endmodule
